[hw/rtl/ftlp_pkg.sv]
package ftlp_pkg;

    localparam int MAX_EVENTS    = 8;
    localparam int EV_IDX_W      = $clog2(MAX_EVENTS);
    localparam int EV_CNT_W      = $clog2(MAX_EVENTS + 1);
    localparam int CHAR_W        = 21;
    localparam int QL_W          = 8;
    localparam int QUOTE_MAX_DEF = 255;

    // event kinds
    localparam logic [1:0] EV_BEGIN = 2'd0;
    localparam logic [1:0] EV_CHAR  = 2'd1;
    localparam logic [1:0] EV_WRAP  = 2'd2;
    localparam logic [1:0] EV_END   = 2'd3;

    // characters of interest
    localparam logic [CHAR_W-1:0] CH_LF   = 21'h0A;
    localparam logic [CHAR_W-1:0] CH_CR   = 21'h0D;
    localparam logic [CHAR_W-1:0] CH_SP   = 21'h20;
    localparam logic [CHAR_W-1:0] CH_DASH = 21'h2D;
    localparam logic [CHAR_W-1:0] CH_GT   = 21'h3E;

    // configuration register indexes
    localparam int         CFG_IDX_W  = 1;
    localparam logic [0:0] CFG_FLOWED = 1'b0;
    localparam logic [0:0] CFG_DELSP  = 1'b1;

    typedef struct packed {
        logic [CHAR_W-1:0] code_point;
        logic              end_of_text;
    } t_in;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [CHAR_W-1:0] out_char;
        logic [QL_W-1:0]   line_quote_level;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] ch;
        logic [QL_W-1:0]   ql;
    } t_event;

    // all events caused by one input word
    typedef struct packed {
        t_event [MAX_EVENTS-1:0] ev;
        logic [EV_CNT_W-1:0]     cnt;
    } t_bundle;

    // characters of the signature marker "-- "
    function automatic logic [CHAR_W-1:0] f_sig_char(input logic [1:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            2'd0:    ch = CH_DASH;
            2'd1:    ch = CH_DASH;
            2'd2:    ch = CH_SP;
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

[hw/rtl/ftlp_step.sv]
module ftlp_step #(
    parameter int QUOTE_MAX = ftlp_pkg::QUOTE_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  ftlp_pkg::t_in     i_item,
    input  logic              i_flowed,
    input  logic              i_delsp,
    output ftlp_pkg::t_bundle o_bundle
);
    import ftlp_pkg::*;

    localparam int QW = $clog2(QUOTE_MAX + 1);

    typedef enum logic [2:0] {
        PH_SOL,
        PH_QUOTE,
        PH_STUFF,
        PH_SIG,
        PH_SIGDONE,
        PH_TEXT,
        PH_SPACE
    } t_phase;

    typedef struct packed {
        logic          seen_cr;
        t_phase        phase;
        logic [QW-1:0] quote;
        logic [QW-1:0] prior_quote;
        logic          prior_flowed;
        logic          flowed_into;
        logic [1:0]    sig_cnt;
    } t_st;

    typedef struct packed {
        t_st     st;
        t_bundle b;
    } t_ctx;

    localparam t_st ST_RESET = '{
        seen_cr:      1'b0,
        phase:        PH_SOL,
        quote:        '0,
        prior_quote:  '0,
        prior_flowed: 1'b0,
        flowed_into:  1'b0,
        sig_cnt:      2'd0
    };

    t_st  r_st;
    t_st  n_st;
    t_ctx w_ctx;

    function automatic t_ctx f_emit(input t_ctx c, input logic [1:0] kind,
                                    input logic [CHAR_W-1:0] ch,
                                    input logic [QL_W-1:0] ql);
        t_ctx r;
        r = c;
        if (r.b.cnt < EV_CNT_W'(MAX_EVENTS)) begin
            r.b.ev[r.b.cnt[EV_IDX_W-1:0]] = '{kind: kind, ch: ch, ql: ql};
            r.b.cnt = r.b.cnt + EV_CNT_W'(1);
        end
        return r;
    endfunction

    function automatic t_ctx f_begin(input t_ctx c);
        return f_emit(c, EV_BEGIN, '0, QL_W'(c.st.quote));
    endfunction

    function automatic t_ctx f_end(input t_ctx c);
        return f_emit(c, EV_END, '0, '0);
    endfunction

    function automatic t_ctx f_text(input t_ctx c, input logic [CHAR_W-1:0] ch,
                                    input logic eof, input logic fm);
        t_ctx r;
        r = c;
        if (eof || ch == CH_LF) begin
            r = f_end(r);
            r.st.phase = PH_SOL;
        end else if (ch == CH_SP && fm) begin
            r.st.phase = PH_SPACE;
        end else begin
            r = f_emit(r, EV_CHAR, ch, '0);
        end
        return r;
    endfunction

    function automatic t_ctx f_space(input t_ctx c, input logic [CHAR_W-1:0] ch,
                                     input logic eof, input logic fm, input logic ds);
        t_ctx r;
        r = c;
        r.st.phase = PH_TEXT;
        if (eof || ch != CH_LF) begin
            r = f_emit(r, EV_CHAR, CH_SP, '0);
            r = f_text(r, ch, eof, fm);
        end else begin
            // trailing space: line flows into the next one
            if (!(fm && ds))
                r = f_emit(r, EV_CHAR, CH_SP, '0);
            r.st.prior_flowed = 1'b1;
            r.st.prior_quote  = r.st.quote;
            r.st.phase        = PH_SOL;
        end
        return r;
    endfunction

    function automatic t_ctx f_tail(input t_ctx c, input logic [CHAR_W-1:0] ch,
                                    input logic eof, input logic fm, input logic ds);
        t_ctx r;
        if (c.st.phase == PH_SPACE)
            r = f_space(c, ch, eof, fm, ds);
        else
            r = f_text(c, ch, eof, fm);
        return r;
    endfunction

    function automatic t_ctx f_not_sig(input t_ctx c, input logic [CHAR_W-1:0] ch,
                                       input logic eof, input logic fm, input logic ds);
        t_ctx r;
        r = c;
        if (r.st.flowed_into)
            r = f_emit(r, EV_WRAP, '0, '0);
        r.st.phase = PH_TEXT;
        // replay the part of the marker held back so far
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < c.st.sig_cnt)
                r = f_tail(r, f_sig_char(2'(k)), 1'b0, fm, ds);
        end
        r.st.sig_cnt = 2'd0;
        r = f_tail(r, ch, eof, fm, ds);
        return r;
    endfunction

    function automatic t_ctx f_sig(input t_ctx c, input logic [CHAR_W-1:0] ch,
                                   input logic eof, input logic fm, input logic ds);
        t_ctx r;
        r = c;
        if (!eof && r.st.sig_cnt < 2'd3 && ch == f_sig_char(r.st.sig_cnt)) begin
            r.st.sig_cnt = r.st.sig_cnt + 2'd1;
            if (r.st.sig_cnt == 2'd3)
                r.st.phase = PH_SIGDONE;
        end else begin
            r = f_not_sig(r, ch, eof, fm, ds);
        end
        return r;
    endfunction

    function automatic t_ctx f_sigdone(input t_ctx c, input logic [CHAR_W-1:0] ch,
                                       input logic eof, input logic fm, input logic ds);
        t_ctx r;
        r = c;
        if (eof || ch == CH_LF) begin
            if (r.st.flowed_into) begin
                r = f_end(r);
                r = f_begin(r);
                r.st.flowed_into = 1'b0;
            end
            r.st.phase   = PH_SOL;
            r.st.sig_cnt = 2'd0;
            r = f_emit(r, EV_CHAR, CH_DASH, '0);
            r = f_emit(r, EV_CHAR, CH_DASH, '0);
            r = f_emit(r, EV_CHAR, CH_SP, '0);
            r = f_end(r);
        end else begin
            r = f_not_sig(r, ch, eof, fm, ds);
        end
        return r;
    endfunction

    function automatic t_ctx f_start(input t_ctx c, input logic [CHAR_W-1:0] ch,
                                     input logic eof, input logic fm, input logic ds);
        t_ctx r;
        r = c;
        r.st.phase   = PH_SIG;
        r.st.sig_cnt = 2'd0;
        if (!eof && ch == CH_LF && r.st.flowed_into) begin
            r = f_end(r);
            r = f_begin(r);
            r.st.flowed_into = 1'b0;
        end
        r = f_sig(r, ch, eof, fm, ds);
        return r;
    endfunction

    function automatic t_ctx f_counted(input t_ctx c, input logic [CHAR_W-1:0] ch,
                                       input logic eof, input logic fm, input logic ds);
        t_ctx r;
        r = c;
        r.st.flowed_into = 1'b0;
        if (r.st.prior_flowed && r.st.quote == r.st.prior_quote) begin
            r.st.flowed_into = 1'b1;
        end else begin
            if (r.st.prior_flowed)
                r = f_end(r);
            r = f_begin(r);
        end
        r.st.prior_flowed = 1'b0;
        if (!fm) begin
            r.st.phase = PH_TEXT;
            r = f_text(r, ch, eof, fm);
        end else if (!eof && ch == CH_SP) begin
            r.st.phase = PH_STUFF;
        end else begin
            r = f_start(r, ch, eof, fm, ds);
        end
        return r;
    endfunction

    function automatic t_ctx f_quote(input t_ctx c, input logic [CHAR_W-1:0] ch,
                                     input logic eof, input logic fm, input logic ds);
        t_ctx r;
        r = c;
        if (!eof && ch == CH_GT && fm) begin
            if (r.st.quote < QW'(QUOTE_MAX))
                r.st.quote = r.st.quote + QW'(1);
        end else begin
            r = f_counted(r, ch, eof, fm, ds);
        end
        return r;
    endfunction

    function automatic t_ctx f_content(input t_ctx c, input logic [CHAR_W-1:0] ch,
                                       input logic eof, input logic fm, input logic ds);
        t_ctx r;
        r = c;
        case (c.st.phase)
            PH_QUOTE:   r = f_quote(r, ch, eof, fm, ds);
            PH_STUFF:   r = f_start(r, ch, eof, fm, ds);
            PH_SIG:     r = f_sig(r, ch, eof, fm, ds);
            PH_SIGDONE: r = f_sigdone(r, ch, eof, fm, ds);
            PH_TEXT:    r = f_tail(r, ch, eof, fm, ds);
            PH_SPACE:   r = f_tail(r, ch, eof, fm, ds);
            default: begin
                if (eof) begin
                    if (r.st.prior_flowed)
                        r = f_end(r);
                end else begin
                    r.st.phase = PH_QUOTE;
                    r.st.quote = '0;
                    r = f_quote(r, ch, eof, fm, ds);
                end
            end
        endcase
        return r;
    endfunction

    always_comb begin
        w_ctx      = '0;
        w_ctx.st   = r_st;
        // a held CR is content unless this word is its LF
        if (r_st.seen_cr) begin
            w_ctx.st.seen_cr = 1'b0;
            if (i_item.end_of_text || i_item.code_point != CH_LF)
                w_ctx = f_content(w_ctx, CH_CR, 1'b0, i_flowed, i_delsp);
        end
        if (i_item.end_of_text) begin
            w_ctx    = f_content(w_ctx, '0, 1'b1, i_flowed, i_delsp);
            w_ctx.st = ST_RESET;
        end else if (i_item.code_point == CH_CR) begin
            w_ctx.st.seen_cr = 1'b1;
        end else begin
            w_ctx = f_content(w_ctx, i_item.code_point, 1'b0, i_flowed, i_delsp);
        end
    end

    assign n_st     = i_take ? w_ctx.st : r_st;
    assign o_bundle = w_ctx.b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

[hw/rtl/ftlp_serial.sv]
module ftlp_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ftlp_pkg::t_bundle i_bundle,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_stall,
    output ftlp_pkg::t_out    o_data
);
    import ftlp_pkg::*;

    t_bundle             r_bundle;
    logic                r_valid;
    logic [EV_IDX_W-1:0] r_idx;
    logic                n_valid;
    logic [EV_IDX_W-1:0] n_idx;
    logic                w_last;
    logic                w_take;
    t_event              w_ev;

    assign w_ev   = r_bundle.ev[r_idx];
    assign w_last = (EV_CNT_W'(r_idx) + EV_CNT_W'(1)) == r_bundle.cnt;
    assign w_take = r_valid && !i_stall;
    assign o_room = !r_valid || (w_take && w_last);

    assign o_valid = r_valid;
    assign o_data  = '{event_kind: w_ev.kind, out_char: w_ev.ch,
                       line_quote_level: w_ev.ql, last: w_last};

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = '0;
        end else if (w_take) begin
            if (w_last)
                n_valid = 1'b0;
            else
                n_idx = r_idx + EV_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load)
            r_bundle <= i_bundle;
    end

endmodule

[hw/rtl/flowed_text_line_parser_core.sv]
// Flowed text line parser core.
// Input channel (i_in_valid / o_in_stall / i_in_data): one word per character,
// a code point or an end-of-text mark. Output channel (o_out_valid /
// i_out_stall / o_out_data): logical-line events - line begin with quote
// level, content character, flowed wrap, line end - with last set on the
// final event caused by each input word.
// Configuration (i_cfg_we / i_cfg_index / i_cfg_wdata): index 0 selects
// flowed handling, index 1 delete-space; write only while the core is idle.
// The first event of a word leaves through the input register, then the event
// register. Throughput: one word per cycle while each word gives at most one
// event and the receiver does not stall; a word with several events holds
// the next word back until its last event is taken. Words that give no event
// (a CR, quote marks in flowed mode) retire without touching the output.
// Reset (i_rst_n, synchronous, active low) clears the parser state, the
// configuration and both pipeline valid flags. A stalled receiver holds the
// event on the output; the input stalls once its register cannot advance.
module flowed_text_line_parser_core #(
    parameter int QUOTE_MAX = ftlp_pkg::QUOTE_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ftlp_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ftlp_pkg::t_out                   o_out_data,
    input  logic                             i_cfg_we,
    input  logic [ftlp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic                             i_cfg_wdata
);
    import ftlp_pkg::*;

    t_in     r_in;
    logic    r_in_valid;
    logic    n_in_valid;
    logic    r_flowed;
    logic    r_delsp;
    logic    w_accept;
    logic    w_adv;
    logic    w_room;
    t_bundle w_bundle;

    // Advance the held word when it makes no event, or when the event
    // register is empty or frees up this cycle.
    assign w_adv      = r_in_valid && ((w_bundle.cnt == '0) || w_room);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept)
            n_in_valid = 1'b1;
        else if (w_adv)
            n_in_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_flowed   <= 1'b0;
            r_delsp    <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FLOWED: r_flowed <= i_cfg_wdata;
                    CFG_DELSP:  r_delsp  <= i_cfg_wdata;
                    default:    ;
                endcase
            end
        end
    end

    // hold the input word until it advances
    always_ff @(posedge i_clk) begin
        if (w_accept)
            r_in <= i_in_data;
    end

    ftlp_step #(
        .QUOTE_MAX(QUOTE_MAX)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_adv),
        .i_item  (r_in),
        .i_flowed(r_flowed),
        .i_delsp (r_delsp),
        .o_bundle(w_bundle)
    );

    ftlp_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv && (w_bundle.cnt != '0)),
        .i_bundle(w_bundle),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

[sim/tb_flowed_text_line_parser_core.sv]
`timescale 1ns / 1ps

module tb_flowed_text_line_parser_core;

    import ftlp_pkg::*;

    // Run shape
    localparam int          WORDS_PER_PHASE = 40;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          HOLD_CYCLES     = 80;
    localparam int unsigned CYCLE_LIMIT     = 500_000;

    // Signature marker "-- ", index 0 first
    localparam logic [2:0][CHAR_W-1:0] SIG_MARK = {CH_SP, CH_DASH, CH_DASH};

    // Parser position within the current line
    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_QUOTES,
        PH_STUFFED,
        PH_SIG_MATCH,
        PH_SIG_FULL,
        PH_BODY,
        PH_HELD_SPACE
    } t_phase;

    // One row of the directed script. Where typed is set, the events of the
    // word are written out here (at most two) instead of being predicted.
    typedef struct packed {
        logic [CHAR_W-1:0] cp;
        logic              eot;
        logic              typed;
        logic [1:0]        n_events;
        t_out              first_ev;
        t_out              second_ev;
    } t_script_row;

    localparam t_out NO_EVENT = '0;

    localparam int SCRIPT_LEN  = 27;
    // rows from here on run with flowed handling on, delete-space off
    localparam int FLOWED_FROM = 9;

    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        // plain mode, straight after reset
        '{21'h000000, 1'b1, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
        '{21'h000041, 1'b0, 1'b1, 2'd2, '{EV_BEGIN, 21'h0, 8'd0, 1'b0},
                                        '{EV_CHAR, 21'h41, 8'd0, 1'b1}},
        '{21'h1FFFFF, 1'b0, 1'b1, 2'd1, '{EV_CHAR, 21'h1FFFFF, 8'd0, 1'b1}, NO_EVENT},
        '{21'h000000, 1'b0, 1'b1, 2'd1, '{EV_CHAR, 21'h0, 8'd0, 1'b1}, NO_EVENT},
        '{CH_GT,      1'b0, 1'b1, 2'd1, '{EV_CHAR, CH_GT, 8'd0, 1'b1}, NO_EVENT},
        '{CH_CR,      1'b0, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
        '{CH_LF,      1'b0, 1'b1, 2'd1, '{EV_END, 21'h0, 8'd0, 1'b1}, NO_EVENT},
        '{CH_CR,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{21'h1FFFFF, 1'b1, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        // flowed: ">> h " then LF, a stuffed space and a flowing line
        '{CH_GT,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{CH_GT,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{CH_SP,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{21'h000068, 1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{CH_SP,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{CH_LF,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        // ">>i" joins the paragraph above
        '{CH_GT,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{CH_GT,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{21'h000069, 1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{CH_LF,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        // signature separator line
        '{CH_DASH,    1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{CH_DASH,    1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{CH_SP,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{CH_LF,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        // "z " flows, then the text ends on a fresh line
        '{21'h00007A, 1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{CH_SP,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{CH_LF,      1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
        '{21'h000000, 1'b1, 1'b1, 2'd1, '{EV_END, 21'h0, 8'd0, 1'b1}, NO_EVENT}
    };

    // Block inputs, known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in                  in_data   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FLOWED;
    logic                 cfg_wdata = 1'b0;

    logic                 in_stall;
    logic                 out_valid;
    t_out                 out_data;

    // Idling profile and the long receiver hold-off request
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req       = 1'b0;

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;

    // Line parser shadow: register copies and parser state
    logic        mode_flowed    = 1'b0;
    logic        mode_delsp     = 1'b0;
    logic        cr_held        = 1'b0;
    t_phase      phase          = PH_LINE_START;
    int unsigned quote_lvl      = 0;
    int unsigned prev_quote_lvl = 0;
    logic        prev_flowed    = 1'b0;
    logic        joined         = 1'b0;
    int unsigned dash_count     = 0;

    t_out word_events[$];   // events of the word just accepted
    t_out events_due[$];    // line events still to arrive, oldest first
    t_in  line_words[$];    // words of the line being composed

    flowed_text_line_parser_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Line event prediction
    // ------------------------------------------------------------------

    // Append one event; anything past the per-word maximum is dropped
    function automatic void put_event(logic [1:0] kind, logic [CHAR_W-1:0] ch,
                                      logic [QL_W-1:0] ql);
        if (word_events.size() < MAX_EVENTS) begin
            word_events.push_back(t_out'{kind, ch, ql, 1'b0});
        end
    endfunction

    // Plain body text: LF or end closes the line, a space may be a flow mark
    function automatic void body_char(logic [CHAR_W-1:0] c, logic eot);
        if (eot || c == CH_LF) begin
            put_event(EV_END, '0, '0);
            phase = PH_LINE_START;
        end else if (c == CH_SP && mode_flowed) begin
            phase = PH_HELD_SPACE;
        end else begin
            put_event(EV_CHAR, c, '0);
        end
    endfunction

    // Body text, settling a held space first: space then LF marks a flowed line
    function automatic void tail_char(logic [CHAR_W-1:0] c, logic eot);
        if (phase != PH_HELD_SPACE) begin
            body_char(c, eot);
        end else begin
            phase = PH_BODY;
            if (eot || c != CH_LF) begin
                put_event(EV_CHAR, CH_SP, '0);
                body_char(c, eot);
            end else begin
                if (!(mode_flowed && mode_delsp)) begin
                    put_event(EV_CHAR, CH_SP, '0);
                end
                prev_flowed    = 1'b1;
                prev_quote_lvl = quote_lvl;
                phase          = PH_LINE_START;
            end
        end
    endfunction

    // Not a signature after all: flag the wrap, replay the matched prefix
    function automatic void break_signature(logic [CHAR_W-1:0] c, logic eot);
        int unsigned k;
        if (joined) begin
            put_event(EV_WRAP, '0, '0);
        end
        phase = PH_BODY;
        for (k = 0; k < dash_count && k < 3; k++) begin
            tail_char(SIG_MARK[k], 1'b0);
        end
        dash_count = 0;
        tail_char(c, eot);
    endfunction

    function automatic void signature_char(logic [CHAR_W-1:0] c, logic eot);
        if (!eot && dash_count < 3 && c == SIG_MARK[dash_count]) begin
            dash_count++;
            if (dash_count == 3) begin
                phase = PH_SIG_FULL;
            end
        end else begin
            break_signature(c, eot);
        end
    endfunction

    // First character after the quote marks (and any stuffed space)
    function automatic void open_content(logic [CHAR_W-1:0] c, logic eot);
        phase      = PH_SIG_MATCH;
        dash_count = 0;
        if (!eot && c == CH_LF && joined) begin
            // an empty line ends the flowing paragraph
            put_event(EV_END, '0, '0);
            put_event(EV_BEGIN, '0, quote_lvl[QL_W-1:0]);
            joined = 1'b0;
        end
        signature_char(c, eot);
    endfunction

    function automatic void quote_mark_char(logic [CHAR_W-1:0] c, logic eot);
        if (!eot && c == CH_GT && mode_flowed) begin
            if (quote_lvl < QUOTE_MAX_DEF) begin
                quote_lvl++;
            end
        end else begin
            // quote prefix done: join the flowed line above or open a new one
            joined = prev_flowed && quote_lvl == prev_quote_lvl;
            if (!joined) begin
                if (prev_flowed) begin
                    put_event(EV_END, '0, '0);
                end
                put_event(EV_BEGIN, '0, quote_lvl[QL_W-1:0]);
            end
            prev_flowed = 1'b0;
            if (!mode_flowed) begin
                phase = PH_BODY;
                body_char(c, eot);
            end else if (!eot && c == CH_SP) begin
                phase = PH_STUFFED;
            end else begin
                open_content(c, eot);
            end
        end
    endfunction

    function automatic void parse_char(logic [CHAR_W-1:0] c, logic eot);
        int unsigned k;
        case (phase)
            PH_QUOTES:    quote_mark_char(c, eot);
            PH_STUFFED:   open_content(c, eot);
            PH_SIG_MATCH: signature_char(c, eot);
            PH_SIG_FULL: begin
                if (eot || c == CH_LF) begin
                    // signature stands as a line of its own
                    if (joined) begin
                        put_event(EV_END, '0, '0);
                        put_event(EV_BEGIN, '0, quote_lvl[QL_W-1:0]);
                        joined = 1'b0;
                    end
                    phase      = PH_LINE_START;
                    dash_count = 0;
                    for (k = 0; k < 3; k++) begin
                        put_event(EV_CHAR, SIG_MARK[k], '0);
                    end
                    put_event(EV_END, '0, '0);
                end else begin
                    break_signature(c, eot);
                end
            end
            PH_BODY, PH_HELD_SPACE: tail_char(c, eot);
            default: begin
                if (eot) begin
                    if (prev_flowed) begin
                        put_event(EV_END, '0, '0);
                    end
                end else begin
                    phase     = PH_QUOTES;
                    quote_lvl = 0;
                    quote_mark_char(c, eot);
                end
            end
        endcase
    endfunction

    // Work out every line event that one accepted word causes
    function automatic void predict_line_events(t_in w);
        t_out tail;
        word_events.delete();
        if (cr_held) begin
            cr_held = 1'b0;
            // CR LF collapses; any other follower releases the CR as text
            if (w.end_of_text || w.code_point != CH_LF) begin
                parse_char(CH_CR, 1'b0);
            end
        end
        if (w.end_of_text) begin
            parse_char('0, 1'b1);
            cr_held        = 1'b0;
            phase          = PH_LINE_START;
            quote_lvl      = 0;
            prev_quote_lvl = 0;
            prev_flowed    = 1'b0;
            joined         = 1'b0;
            dash_count     = 0;
        end else if (w.code_point == CH_CR) begin
            cr_held = 1'b1;
        end else begin
            parse_char(w.code_point, 1'b0);
        end
        if (word_events.size() != 0) begin
            tail      = word_events.pop_back();
            tail.last = 1'b1;
            word_events.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Random text
    // ------------------------------------------------------------------

    function automatic void add_char(logic [CHAR_W-1:0] cp);
        line_words.push_back(t_in'{cp, 1'b0});
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 25) return CH_SP;
        if (r < 55) return CHAR_W'(32'h61 + $urandom_range(25));
        if (r < 62) return CH_DASH;
        if (r < 68) return CH_GT;
        if (r < 72) return CH_CR;
        if (r < 75) return CH_LF;
        if (r < 88) return CHAR_W'($urandom_range(32'h10FFFF));
        // anywhere in the field, beyond the Unicode range too
        return CHAR_W'($urandom);
    endfunction

    // Compose one line: quote marks, stuffing, body, terminator, maybe the end
    function automatic void build_line(bit deep_quote);
        int unsigned r;
        int unsigned n_gt;
        line_words.delete();
        r = $urandom_range(99);
        if (r < 8 && !deep_quote) begin
            // noise: raw words, now and then an end of text
            repeat ($urandom_range(1, 6)) begin
                line_words.push_back(t_in'{CHAR_W'($urandom), $urandom_range(19) == 0});
            end
            return;
        end
        if (deep_quote) begin
            n_gt = $urandom_range(254, 262);
        end else if ($urandom_range(2) == 0) begin
            n_gt = 0;
        end else begin
            n_gt = $urandom_range(1, 3);
        end
        repeat (n_gt) add_char(CH_GT);
        if ($urandom_range(1) == 1) begin
            add_char(CH_SP);
        end
        r = $urandom_range(99);
        if (r < 12) begin
            add_char(CH_DASH);
            add_char(CH_DASH);
            add_char(CH_SP);
        end else if (r < 17) begin
            add_char(CH_DASH);
            add_char(CH_DASH);
            add_char(CH_SP);
            add_char(pick_char());
        end else if (r < 24) begin
            add_char(CH_DASH);
            if ($urandom_range(1) == 1) begin
                add_char(CH_DASH);
            end
            add_char(pick_char());
        end else if (r >= 32) begin
            repeat ($urandom_range(1, 8)) add_char(pick_char());
        end
        r = $urandom_range(99);
        if (r < 40) begin
            add_char(CH_SP);
            add_char(CH_LF);
        end else if (r < 60) begin
            add_char(CH_CR);
            add_char(CH_LF);
        end else if (r < 90) begin
            add_char(CH_LF);
        end else if (r < 95) begin
            add_char(CH_CR);
        end
        // otherwise the line runs on into the next one
        if ($urandom_range(11) == 0) begin
            line_words.push_back(t_in'{CHAR_W'($urandom), 1'b1});
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one word, idling first at random; return at the accepting edge
    // with its events predicted. Valid stays high for a following word.
    task automatic send_word(input t_in w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_line_events(w);
    endtask

    // Drop valid, wait for every expected event, then let stray words retire
    task automatic settle();
        in_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_modes(input logic flowed, input logic delsp);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FLOWED;
        cfg_wdata <= flowed;
        @(posedge clk);
        cfg_index <= CFG_DELSP;
        cfg_wdata <= delsp;
        @(posedge clk);
        cfg_we      <= 1'b0;
        mode_flowed  = flowed;
        mode_delsp   = delsp;
    endtask

    // Receiver stall: random per cycle, or one long hold-off on request
    initial begin : stall_gen
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Compare every accepted event with the oldest one due
    always @(posedge clk) begin : check_event
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (events_due.size() == 0) begin
                $error("unexpected event: kind %0d char %h level %0d",
                       out_data.event_kind, out_data.out_char, out_data.line_quote_level);
                mismatch_count++;
            end else begin
                want = events_due.pop_front();
                if (out_data.event_kind !== want.event_kind) begin
                    $error("event_kind: expected %0d, got %0d",
                           want.event_kind, out_data.event_kind);
                    mismatch_count++;
                end
                if (out_data.out_char !== want.out_char) begin
                    $error("out_char: expected %h, got %h", want.out_char, out_data.out_char);
                    mismatch_count++;
                end
                if (out_data.line_quote_level !== want.line_quote_level) begin
                    $error("line_quote_level: expected %0d, got %0d",
                           want.line_quote_level, out_data.line_quote_level);
                    mismatch_count++;
                end
                if (out_data.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, out_data.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        t_script_row row;
        int          i;
        int          p;
        int          sent;
        bit          first_line;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script, first nine rows on the reset register values
        send_idle_pct  = 15;
        recv_stall_pct = 57;
        for (i = 0; i < SCRIPT_LEN; i++) begin
            if (i == FLOWED_FROM) begin
                settle();
                set_modes(1'b1, 1'b0);
            end
            row = SCRIPT[i];
            send_word(t_in'{row.cp, row.eot});
            if (row.typed) begin
                if (row.n_events >= 1) events_due.push_back(row.first_ev);
                if (row.n_events >= 2) events_due.push_back(row.second_ev);
            end else begin
                foreach (word_events[k]) events_due.push_back(word_events[k]);
            end
        end

        // Random text over four register settings:
        //   flowed+delsp, plain, flowed only, flowed+delsp again.
        // Idling: sender light / receiver heavy, then swapped, then none.
        for (p = 0; p < 4; p++) begin
            settle();
            set_modes(p != 1, p != 2);
            send_idle_pct  = (p == 0) ? 15 : (p == 1) ? 57 : 0;
            recv_stall_pct = (p == 0) ? 57 : (p == 1) ? 15 : 0;
            // hold the receiver off while words keep coming, to fill the core
            if (p == 2) hold_req = 1'b1;
            sent       = 0;
            first_line = 1'b1;
            while (sent < WORDS_PER_PHASE) begin
                // open the last phase with a quote run near or past saturation
                build_line(first_line && p == 3);
                first_line = 1'b0;
                foreach (line_words[j]) begin
                    send_word(line_words[j]);
                    foreach (word_events[k]) events_due.push_back(word_events[k]);
                    sent++;
                end
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
